>>> design/rmhd_pkg.sv
package rmhd_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ETA_BITS  = WORD_BITS - 1;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [ETA_BITS-1:0]         eta_t;
  typedef logic [WORD_BITS-1:0]        inv_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [1:0] DIM_3D    = 2'd3;
  localparam inv_t       INV_RESET = inv_t'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    REG_DIMENSION = 2'd0,
    REG_INV_DX    = 2'd1,
    REG_INV_DY    = 2'd2,
    REG_INV_DZ    = 2'd3
  } cfg_reg_t;

  // load enables of the two register stages inside one multiplier
  typedef struct packed {
    logic load_prod;
    logic load_res;
  } qmul_ctl_t;

endpackage

>>> design/rmhd_ifs.sv
interface rmhd_in_if;
  import rmhd_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          axis;
  logic signed [WORD_BITS-1:0] center_bx;
  logic signed [WORD_BITS-1:0] center_by;
  logic signed [WORD_BITS-1:0] center_bz;
  logic signed [WORD_BITS-1:0] normal_nb_b;
  logic signed [WORD_BITS-1:0] normal_nb_c;
  logic signed [WORD_BITS-1:0] side_b_a;
  logic signed [WORD_BITS-1:0] side_c_a;
  logic [ETA_BITS-1:0] eta_center;
  logic [ETA_BITS-1:0] eta_neighbor;

  modport source (
    output valid, axis, center_bx, center_by, center_bz, normal_nb_b, normal_nb_c,
           side_b_a, side_c_a, eta_center, eta_neighbor,
    input  ready
  );
  modport sink (
    input  valid, axis, center_bx, center_by, center_bz, normal_nb_b, normal_nb_c,
           side_b_a, side_c_a, eta_center, eta_neighbor,
    output ready
  );
endinterface

interface rmhd_out_if;
  import rmhd_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [WORD_BITS-1:0] res_energy;
  logic signed [WORD_BITS-1:0] res_bx;
  logic signed [WORD_BITS-1:0] res_by;
  logic signed [WORD_BITS-1:0] res_bz;
  logic [ETA_BITS-1:0] eta_face;

  modport source (
    output valid, res_energy, res_bx, res_by, res_bz, eta_face,
    input  ready
  );
  modport sink (
    input  valid, res_energy, res_bx, res_by, res_bz, eta_face,
    output ready
  );
endinterface

>>> design/rmhd_qmul.sv
module rmhd_qmul #(
  parameter int A_W = rmhd_pkg::WORD_BITS,
  parameter int B_W = rmhd_pkg::WORD_BITS
) (
  input  logic                              clk,
  input  rmhd_pkg::qmul_ctl_t               ctl,
  input  logic signed [A_W-1:0]             a,
  input  logic signed [B_W-1:0]             b,
  output logic signed [rmhd_pkg::WORD_BITS-1:0] y
);
  import rmhd_pkg::*;

  localparam int PW = A_W + B_W;
  localparam int RW = PW + 1 - FRAC_BITS;
  localparam logic [RW-1:0] POS_LIM = RW'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic [RW-1:0] NEG_LIM = RW'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam logic [PW:0]   HALF    = (PW+1)'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_r, prod_nxt;
  word_t                y_r, y_nxt;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic [PW:0]          rnd;
  logic [RW-1:0]        quo;

  assign prod_nxt = a * b;

  // magnitude, round half away from zero, saturate to the word
  always_comb begin
    neg = prod_r[PW-1];
    mag = neg ? PW'(-prod_r) : PW'(prod_r);
    rnd = {1'b0, mag} + HALF;
    quo = rnd[PW:FRAC_BITS];
    if (!neg) begin
      y_nxt = (quo > POS_LIM) ? WORD_MAX : word_t'(quo[WORD_BITS-1:0]);
    end else begin
      y_nxt = (quo >= NEG_LIM) ? WORD_MIN : word_t'(-quo[WORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.load_res) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

>>> design/resistive_mhd_face_flux_top.sv
// channel   dir  handshake             word
// in_ch     in   valid/ready           axis, center field, neighbor fields, two resistivities
// out_ch    out  valid/ready           energy flux, bx/by/bz flux, face resistivity
// apb       in   psel/penable/pready   dimension, inv_dx, inv_dy, inv_dz at 0x0/0x4/0x8/0xc
//
// nine register stages: select, three multiply/round pairs and two combine stages
// one face enters per cycle unless every stage is full and the output stalls;
// out_ch.valid rises once the accepted face has passed through to the last stage
// rst_n is synchronous; it clears the stage valid bits and loads register defaults
// a stalled output holds; each stage advances whenever it is empty or the stage
// after it moves, so bubbles collapse and no word is lost or repeated
module resistive_mhd_face_flux_top (
  input  logic                           clk,
  input  logic                           rst_n,
  rmhd_in_if.sink                        in_ch,
  rmhd_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmhd_pkg::CFG_AW-1:0]    paddr,
  input  logic [rmhd_pkg::CFG_DW-1:0]    pwdata,
  output logic [rmhd_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);
  import rmhd_pkg::*;

  localparam int NS = 9;

  // saturating word subtract
  function automatic word_t sat_sub(word_t x, word_t y);
    logic signed [WORD_BITS:0] d;
    d = {x[WORD_BITS-1], x} - {y[WORD_BITS-1], y};
    if (d[WORD_BITS] != d[WORD_BITS-1]) begin
      sat_sub = d[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_sub = word_t'(d[WORD_BITS-1:0]);
    end
  endfunction

  // ---------------------------------------------------------------- config
  logic [1:0] dim_r;
  inv_t       inv_dx_r, inv_dy_r, inv_dz_r;
  logic       cfg_wr;
  cfg_reg_t   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r    <= DIM_3D;
      inv_dx_r <= INV_RESET;
      inv_dy_r <= INV_RESET;
      inv_dz_r <= INV_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_DIMENSION: dim_r    <= pwdata[1:0];
        REG_INV_DX:    inv_dx_r <= pwdata[WORD_BITS-1:0];
        REG_INV_DY:    inv_dy_r <= pwdata[WORD_BITS-1:0];
        REG_INV_DZ:    inv_dz_r <= pwdata[WORD_BITS-1:0];
        default:       dim_r    <= dim_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_DIMENSION: prdata = CFG_DW'(dim_r);
      REG_INV_DX:    prdata = CFG_DW'(inv_dx_r);
      REG_INV_DY:    prdata = CFG_DW'(inv_dy_r);
      REG_INV_DZ:    prdata = CFG_DW'(inv_dz_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic [NS:1]   v_r;
  logic [NS+1:1] adv;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NS+1] = out_ch.ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: axis select, differences
  axis_t ax;
  word_t b_a, b_b, b_c;
  inv_t  ia, ib, ic;
  logic  keep_jc, keep_jb;
  logic signed [WORD_BITS:0] d1_nxt, d2_nxt, d3_nxt, d4_nxt, sum_b, sum_c;
  logic [ETA_BITS:0] eta_sum;

  always_comb begin
    // unused axis code behaves as z
    ax = (in_ch.axis == 2'd3) ? AXIS_Z : axis_t'(in_ch.axis);
    case (ax)
      AXIS_X: begin
        b_a = in_ch.center_bx; b_b = in_ch.center_by; b_c = in_ch.center_bz;
        ia  = inv_dx_r;        ib  = inv_dy_r;        ic  = inv_dz_r;
        keep_jc = 1'b1;
        keep_jb = (dim_r == DIM_3D);   // c is z: side_c_a term dropped in 2D
      end
      AXIS_Y: begin
        b_a = in_ch.center_by; b_b = in_ch.center_bz; b_c = in_ch.center_bx;
        ia  = inv_dy_r;        ib  = inv_dz_r;        ic  = inv_dx_r;
        keep_jc = (dim_r == DIM_3D);   // b is z: side_b_a term dropped in 2D
        keep_jb = 1'b1;
      end
      default: begin
        b_a = in_ch.center_bz; b_b = in_ch.center_bx; b_c = in_ch.center_by;
        ia  = inv_dz_r;        ib  = inv_dx_r;        ic  = inv_dy_r;
        keep_jc = 1'b1;
        keep_jb = 1'b1;
      end
    endcase
    d1_nxt  = {b_b[WORD_BITS-1], b_b} - {in_ch.normal_nb_b[WORD_BITS-1], in_ch.normal_nb_b};
    d2_nxt  = {b_a[WORD_BITS-1], b_a} - {in_ch.side_b_a[WORD_BITS-1], in_ch.side_b_a};
    d3_nxt  = {b_a[WORD_BITS-1], b_a} - {in_ch.side_c_a[WORD_BITS-1], in_ch.side_c_a};
    d4_nxt  = {b_c[WORD_BITS-1], b_c} - {in_ch.normal_nb_c[WORD_BITS-1], in_ch.normal_nb_c};
    sum_b   = {b_b[WORD_BITS-1], b_b} + {in_ch.normal_nb_b[WORD_BITS-1], in_ch.normal_nb_b};
    sum_c   = {b_c[WORD_BITS-1], b_c} + {in_ch.normal_nb_c[WORD_BITS-1], in_ch.normal_nb_c};
    eta_sum = {1'b0, in_ch.eta_center} + {1'b0, in_ch.eta_neighbor};
  end

  logic signed [WORD_BITS:0] d1_r, d2_r, d3_r, d4_r;
  inv_t  ia_r, ib_r, ic_r;
  word_t avg_b_r [1:4];
  word_t avg_c_r [1:4];
  logic  keep_jc_r [1:3];
  logic  keep_jb_r [1:3];
  eta_t  eta_r [1:NS];
  axis_t axis_r [1:NS];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      d3_r <= d3_nxt;
      d4_r <= d4_nxt;
      ia_r <= ia;
      ib_r <= ib;
      ic_r <= ic;
      // floor of half the sum always fits the word
      avg_b_r[1]   <= word_t'(sum_b[WORD_BITS:1]);
      avg_c_r[1]   <= word_t'(sum_c[WORD_BITS:1]);
      keep_jc_r[1] <= keep_jc;
      keep_jb_r[1] <= keep_jb;
      eta_r[1]     <= eta_sum[ETA_BITS:1];
      axis_r[1]    <= ax;
    end
    for (int k = 2; k <= 4; k++) begin
      if (adv[k]) begin
        avg_b_r[k] <= avg_b_r[k-1];
        avg_c_r[k] <= avg_c_r[k-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (adv[k]) begin
        keep_jc_r[k] <= keep_jc_r[k-1];
        keep_jb_r[k] <= keep_jb_r[k-1];
      end
    end
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) begin
        eta_r[k]  <= eta_r[k-1];
        axis_r[k] <= axis_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 2-3: spacing products
  qmul_ctl_t ctl_a, ctl_b, ctl_c;
  word_t q1, q2, q3, q4;

  assign ctl_a = '{load_prod: adv[2], load_res: adv[3]};
  assign ctl_b = '{load_prod: adv[5], load_res: adv[6]};
  assign ctl_c = '{load_prod: adv[8], load_res: adv[9]};

  rmhd_qmul #(.A_W(WORD_BITS+1), .B_W(WORD_BITS+1)) u_q1 (
    .clk(clk), .ctl(ctl_a), .a(d1_r), .b(signed'({1'b0, ia_r})), .y(q1)
  );
  rmhd_qmul #(.A_W(WORD_BITS+1), .B_W(WORD_BITS+1)) u_q2 (
    .clk(clk), .ctl(ctl_a), .a(d2_r), .b(signed'({1'b0, ib_r})), .y(q2)
  );
  rmhd_qmul #(.A_W(WORD_BITS+1), .B_W(WORD_BITS+1)) u_q3 (
    .clk(clk), .ctl(ctl_a), .a(d3_r), .b(signed'({1'b0, ic_r})), .y(q3)
  );
  rmhd_qmul #(.A_W(WORD_BITS+1), .B_W(WORD_BITS+1)) u_q4 (
    .clk(clk), .ctl(ctl_a), .a(d4_r), .b(signed'({1'b0, ia_r})), .y(q4)
  );

  // ---------------------------------------------------------------- stage 4: current density
  word_t jc_r, jb_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      jc_r <= keep_jc_r[3] ? sat_sub(q1, q2) : q1;
      jb_r <= keep_jb_r[3] ? sat_sub(q3, q4) : sat_sub('0, q4);
    end
  end

  // ---------------------------------------------------------------- stages 5-6: eta and energy products
  word_t e_b, e_c, t_b, t_c;

  rmhd_qmul #(.A_W(WORD_BITS), .B_W(WORD_BITS)) u_eb (
    .clk(clk), .ctl(ctl_b), .a(avg_b_r[4]), .b(jc_r), .y(e_b)
  );
  rmhd_qmul #(.A_W(WORD_BITS), .B_W(WORD_BITS)) u_ec (
    .clk(clk), .ctl(ctl_b), .a(avg_c_r[4]), .b(jb_r), .y(e_c)
  );
  rmhd_qmul #(.A_W(WORD_BITS), .B_W(WORD_BITS)) u_tb (
    .clk(clk), .ctl(ctl_b), .a(signed'({1'b0, eta_r[4]})), .b(jc_r), .y(t_b)
  );
  rmhd_qmul #(.A_W(WORD_BITS), .B_W(WORD_BITS)) u_tc (
    .clk(clk), .ctl(ctl_b), .a(signed'({1'b0, eta_r[4]})), .b(jb_r), .y(t_c)
  );

  // ---------------------------------------------------------------- stage 7: combine
  word_t diff_r;
  word_t rb_r [7:NS];
  word_t rc_r [7:NS];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      diff_r <= sat_sub(e_b, e_c);
      rb_r[7] <= t_b;
      rc_r[7] <= sat_sub('0, t_c);
    end
    for (int k = 8; k <= NS; k++) begin
      if (adv[k]) begin
        rb_r[k] <= rb_r[k-1];
        rc_r[k] <= rc_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 8-9: energy
  word_t energy;

  rmhd_qmul #(.A_W(WORD_BITS), .B_W(WORD_BITS)) u_en (
    .clk(clk), .ctl(ctl_c), .a(signed'({1'b0, eta_r[7]})), .b(diff_r), .y(energy)
  );

  // ---------------------------------------------------------------- output word
  always_comb begin
    out_ch.valid      = v_r[NS];
    out_ch.res_energy = energy;
    out_ch.eta_face   = eta_r[NS];
    case (axis_r[NS])
      AXIS_X: begin
        out_ch.res_bx = '0;          out_ch.res_by = rb_r[NS]; out_ch.res_bz = rc_r[NS];
      end
      AXIS_Y: begin
        out_ch.res_bx = rc_r[NS];    out_ch.res_by = '0;       out_ch.res_bz = rb_r[NS];
      end
      default: begin
        out_ch.res_bx = rb_r[NS];    out_ch.res_by = rc_r[NS]; out_ch.res_bz = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- checks
  // input can only be taken while a stage has room or the output moves
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (v_r != '1) || out_ch.ready)
    else $error("input accepted into a full stalled pipeline");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[1])
    else $error("accepted word did not reach the first stage");

  a_normal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (axis_r[NS] == AXIS_X && out_ch.res_bx == '0) ||
                     (axis_r[NS] == AXIS_Y && out_ch.res_by == '0) ||
                     (axis_r[NS] == AXIS_Z && out_ch.res_bz == '0))
    else $error("normal component of the flux is not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
